### src/rgb_conv3x3_filter_core_macros.svh
// Assertion macros for the 3x3 convolution filter.
`ifndef RGB_CONV3X3_FILTER_CORE_MACROS_SVH
`define RGB_CONV3X3_FILTER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RCF_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define RCF_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define RCF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### src/rcf_pkg.sv
`default_nettype none
package rcf_pkg;
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_OUT
  } rcf_state_e;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_WEIGHTS = 2'd2;
  localparam logic [1:0] REG_DIVISOR = 2'd3;

  localparam int unsigned PixMax = 255;
  localparam int unsigned Taps   = 9;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // latch input word, read line stores
    logic shift;    // shift window, write line stores, clear step counts
    logic mac;      // one tap of multiply-accumulate
    logic div_step; // one step of the divider
    logic finish;   // register result
  } rcf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic emit;     // current pixel completes an interior window
    logic mac_done;
    logic div_done;
  } rcf_status_t;
endpackage
`default_nettype wire

### src/rgb_conv3x3_filter_core.sv
`default_nettype none
// 3x3 convolution filter for RGB raster video. Each input word is
// accepted while both line stores are read, and then the window shifts;
// a word that completes an interior window then runs the shared tap
// loop and the bit-serial divider, the controller sees the divider
// finish, and the result is registered once the output register is no
// longer full. A new word is taken only after the last one is through.
// Results come for interior centres only, with frame_done on the last one
// of a frame. Line stores need no clearing pass after reset.
module rgb_conv3x3_filter_core #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 4096,
  parameter int unsigned WEIGHT_BITS = 7
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pixel_red, pixel_green, pixel_blue
  input  wire logic [23:0] s_axis_tdata,
  // frame_start
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_red, out_green, out_blue, centre_col, centre_row, zero fill
  output logic [47:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [62:0] cfg_data_i
);
  import rcf_pkg::*;

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [62:0] weights_q;
  logic [7:0]  divisor_q;
  rcf_cmd_t    cmd;
  rcf_status_t status;
  logic [23:0] data_q;
  logic        start_q;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 11'd640;
      height_q  <= 13'd480;
      weights_q <= 63'd268435456;
      divisor_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:   width_q   <= cfg_data_i[10:0];
        REG_HEIGHT:  height_q  <= cfg_data_i[12:0];
        REG_WEIGHTS: weights_q <= cfg_data_i;
        REG_DIVISOR: divisor_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign data_q  = s_axis_tdata;
  assign start_q = s_axis_tuser;

  rcf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcf_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i           (cmd),
    .status_o        (status),
    .in_data_i       (data_q),
    .frame_start_i   (start_q),
    .frame_width_i   (width_q),
    .frame_height_i  (height_q),
    .kernel_weights_i(weights_q),
    .divisor_i       (divisor_q),
    .out_data_o      (m_axis_tdata),
    .frame_done_o    (m_axis_tlast)
  );

`include "rgb_conv3x3_filter_core_macros.svh"
  `RCF_ASSERT_IMPL(a_cmd_excl, clk_i, rst_ni, $onehot0(cmd), "commands overlap")
  `RCF_ASSERT_NEXT(a_load_shift, clk_i, rst_ni, cmd.load, cmd.shift, "shift missing")
  `RCF_ASSERT_IMPL(a_no_load_busy, clk_i, rst_ni, cmd.load |-> s_axis_tready, "load when busy")
endmodule
`default_nettype wire

### src/rcf_ctrl.sv
`default_nettype none
module rcf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire rcf_pkg::rcf_status_t status_i,
  output rcf_pkg::rcf_cmd_t     cmd_o
);
  import rcf_pkg::*;

  rcf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       mac_run_q, mac_run_d;

  // Next state.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    mac_run_d   = mac_run_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        if (status_i.emit) begin
          state_d   = ST_MAC;
          mac_run_d = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MAC: begin
        if (mac_run_q && status_i.mac_done) mac_run_d = 1'b0;
        if (!mac_run_q && status_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o          = '0;
    in_ready_o     = (state_q == ST_IDLE);
    out_valid_o    = out_valid_q;
    unique case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_READ: cmd_o.shift = 1'b1;
      ST_MAC: begin
        cmd_o.mac      = mac_run_q;
        cmd_o.div_step = !mac_run_q;
      end
      ST_OUT:  cmd_o.finish = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mac_run_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      mac_run_q   <= mac_run_d;
    end
  end
endmodule
`default_nettype wire

### src/rcf_datapath.sv
`default_nettype none
module rcf_datapath #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 4096,
  parameter int unsigned WEIGHT_BITS = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rcf_pkg::rcf_cmd_t cmd_i,
  output rcf_pkg::rcf_status_t   status_o,
  input  wire logic [23:0]       in_data_i,
  input  wire logic              frame_start_i,
  input  wire logic [10:0]       frame_width_i,
  input  wire logic [12:0]       frame_height_i,
  input  wire logic [62:0]       kernel_weights_i,
  input  wire logic [7:0]        divisor_i,
  output logic [47:0]            out_data_o,
  output logic                   frame_done_o
);
  import rcf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned SW = 20; // |9*255*64| fits in 20 bits signed
  localparam int unsigned QW = SW - 1;

  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];
  logic [23:0] up_q, mid_q, pix_q;
  logic [23:0] win_q [9];
  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic [CW-1:0] cen_col_q;
  logic [RW-1:0] cen_row_q;
  logic          fdone_q;
  logic [3:0]    tap_q;
  logic signed [SW-1:0] acc_q [3];
  logic [QW-1:0] num_q [3];
  logic [QW-1:0] quo_q [3];
  logic [QW:0]   rem_q [3];
  logic          neg_q [3];
  logic [4:0]    dstep_q;
  logic [7:0]    res_d [3];

  // Clamp geometry into the legal range.
  logic [CW:0] w_sat;
  logic [RW:0] h_sat;
  always_comb begin
    if (frame_width_i < 11'd3) w_sat = (CW+1)'(3);
    else if (32'(frame_width_i) > MAX_WIDTH) w_sat = (CW+1)'(MAX_WIDTH);
    else w_sat = (CW+1)'(frame_width_i);
    if (frame_height_i < 13'd3) h_sat = (RW+1)'(3);
    else if (32'(frame_height_i) > MAX_HEIGHT) h_sat = (RW+1)'(MAX_HEIGHT);
    else h_sat = (RW+1)'(frame_height_i);
  end

  logic [CW:0] w_last;
  logic [RW:0] h_last;
  logic last_col, last_row;
  assign w_last = w_sat - 1'b1;
  assign h_last = h_sat - 1'b1;

  // Position of the held pixel after frame start and geometry clamp.
  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    if ({1'b0, col_cur} > w_last) col_cur = w_last[CW-1:0];
    if ({1'b0, row_cur} > h_last) row_cur = h_last[RW-1:0];
  end
  assign last_col = ({1'b0, col_cur} == w_last);
  assign last_row = ({1'b0, row_cur} == h_last);

  logic [CW-1:0] pos_q;
  logic [RW-1:0] prow_q;
  logic          plc_q, plr_q, pemit_q;

  // Latch word and read both line stores.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q   <= {in_data_i[7:0], in_data_i[15:8], in_data_i[23:16]};
      up_q    <= upper_mem[col_cur];
      mid_q   <= middle_mem[col_cur];
      pos_q   <= col_cur;
      prow_q  <= row_cur;
      plc_q   <= last_col;
      plr_q   <= last_row;
      pemit_q <= (col_cur >= CW'(2)) && (row_cur >= RW'(2));
    end
    if (cmd_i.shift) begin
      upper_mem[pos_q]  <= mid_q;
      middle_mem[pos_q] <= pix_q;
    end
  end

  // Next position.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.load) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_cur + 1'b1;
      end else begin
        col_d = col_cur + 1'b1;
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.shift) begin
        for (int r = 0; r < 3; r++) begin
          win_q[3*r]   <= win_q[3*r+1];
          win_q[3*r+1] <= win_q[3*r+2];
        end
        win_q[2] <= up_q;
        win_q[5] <= mid_q;
        win_q[8] <= pix_q;
      end
    end
  end

  // One tap a cycle for each channel.
  logic signed [WEIGHT_BITS-1:0] wsel;
  logic [23:0] psel;
  logic        mac_done, div_done;
  assign wsel = kernel_weights_i[7*tap_q +: WEIGHT_BITS];
  assign psel = win_q[tap_q];
  assign mac_done = (tap_q == 4'(Taps - 1));

  logic [7:0] div_eff;
  assign div_eff = (divisor_i == 8'd0) ? 8'd1 : divisor_i;
  assign div_done = (dstep_q == 5'(QW));

  assign status_o = '{emit: pemit_q, mac_done: mac_done, div_done: div_done};

  // Widen both operands before the product so nothing is lost.
  logic signed [SW-1:0] prod [3];
  logic signed [SW-1:0] mac_sum [3];
  logic [QW:0]          trial [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]    = SW'($signed({1'b0, psel[8*(2-c) +: 8]})) * SW'(wsel);
      mac_sum[c] = acc_q[c] + prod[c];
      trial[c]   = {rem_q[c][QW-1:0], num_q[c][QW-1]};
    end
  end

  // Clamp the quotient into pixel range.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (neg_q[c] || quo_q[c] == '0) res_d[c] = '0;
      else if (quo_q[c] > QW'(PixMax)) res_d[c] = 8'hFF;
      else res_d[c] = quo_q[c][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      tap_q     <= '0;
      dstep_q   <= '0;
      cen_col_q <= pos_q - 1'b1;
      cen_row_q <= prow_q - 1'b1;
      fdone_q   <= plc_q && plr_q;
      for (int c = 0; c < 3; c++) acc_q[c] <= '0;
    end
    if (cmd_i.mac) begin
      for (int c = 0; c < 3; c++) acc_q[c] <= mac_sum[c];
      tap_q <= tap_q + 1'b1;
      // Capture magnitude on the last tap for the divider.
      if (mac_done) begin
        for (int c = 0; c < 3; c++) begin
          neg_q[c] <= mac_sum[c][SW-1];
          num_q[c] <= mac_sum[c][SW-1] ? QW'(-mac_sum[c]) : QW'(mac_sum[c]);
          quo_q[c] <= '0;
          rem_q[c] <= '0;
        end
      end
    end
    // Restoring division, one quotient bit a cycle.
    if (cmd_i.div_step && !div_done) begin
      for (int c = 0; c < 3; c++) begin
        num_q[c] <= {num_q[c][QW-2:0], 1'b0};
        if (trial[c] >= (QW+1)'(div_eff)) begin
          rem_q[c] <= trial[c] - (QW+1)'(div_eff);
          quo_q[c] <= {quo_q[c][QW-2:0], 1'b1};
        end else begin
          rem_q[c] <= trial[c];
          quo_q[c] <= {quo_q[c][QW-2:0], 1'b0};
        end
      end
      dstep_q <= dstep_q + 1'b1;
    end
    // Register the result word.
    if (cmd_i.finish) begin
      out_data_o   <= {2'd0, 12'(cen_row_q), 10'(cen_col_q),
                       res_d[2], res_d[1], res_d[0]};
      frame_done_o <= fdone_q;
    end
  end
endmodule
`default_nettype wire

### sim/rgb_conv3x3_filter_core_tb.sv
`default_nettype none
module rgb_conv3x3_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 80;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [9:0]  col;
    logic [11:0] row;
    logic        done;
  } filt_word_t;

  typedef struct {
    logic [23:0] pix;
    logic        sof;
    logic        check_fixed;
    filt_word_t  fixed;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [62:0] cfg_data_i;

  rgb_conv3x3_filter_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // Predictor state
  logic [23:0] upper_mem [1024];
  logic [23:0] middle_mem [1024];
  logic [23:0] win [3][3];
  int unsigned col_cnt, row_cnt;
  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic [62:0] cfg_weights;
  logic [7:0]  cfg_div;

  filt_word_t  pending_q[$];
  int unsigned err_count, word_count, res_count;
  int unsigned idle_cycles;
  bit          tx_idle_en, rx_idle_en, long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int signed tap_weight(int unsigned i);
    logic [6:0] slot;
    slot = cfg_weights[7*i +: 7];
    return int'($signed(slot));
  endfunction

  function automatic logic [7:0] filter_chan(int unsigned shift);
    int signed acc, d;
    acc = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        acc += int'((win[r][c] >> shift) & 8'hff) * tap_weight(r*3 + c);
    d = (cfg_div == 0) ? 1 : int'(cfg_div);
    acc = acc / d;
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  // Advance the predictor by one accepted pixel
  function automatic void predict_pixel(logic [23:0] pix, logic sof, output bit emit,
                                        output filt_word_t res);
    int unsigned w, h;
    w = (cfg_width < 3) ? 3 : (cfg_width > 1024) ? 1024 : cfg_width;
    h = (cfg_height < 3) ? 3 : (cfg_height > 4096) ? 4096 : cfg_height;
    if (sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt > w - 1) col_cnt = w - 1;
    if (row_cnt > h - 1) row_cnt = h - 1;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_mem[col_cnt];
    win[1][2] = middle_mem[col_cnt];
    win[2][2] = pix;
    upper_mem[col_cnt] = middle_mem[col_cnt];
    middle_mem[col_cnt] = pix;
    emit = (col_cnt >= 2) && (row_cnt >= 2);
    res = '0;
    if (emit) begin
      // Word layout: red in the low byte, blue in the high byte
      res.red   = filter_chan(0);
      res.green = filter_chan(8);
      res.blue  = filter_chan(16);
      res.col   = 10'(col_cnt - 1);
      res.row   = 12'(row_cnt - 1);
      res.done  = (col_cnt == w - 1) && (row_cnt == h - 1);
    end
    if (col_cnt == w - 1) begin
      row_cnt = (row_cnt == h - 1) ? 0 : row_cnt + 1;
      col_cnt = 0;
    end else begin
      col_cnt++;
    end
  endfunction

  // Write one register on the DUT and the predictor
  task automatic write_reg(logic [1:0] idx, logic [62:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_WIDTH:   cfg_width   = val[10:0];
      REG_HEIGHT:  cfg_height  = val[12:0];
      REG_WEIGHTS: cfg_weights = val;
      REG_DIVISOR: cfg_div     = val[7:0];
      default: ;
    endcase
  endtask

  // Offer one pixel and hold it until accepted; valid stays up afterwards
  task automatic send_pixel(logic [23:0] pix, logic sof);
    bit emit;
    filt_word_t res;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= sof;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(pix, sof, emit, res);
    if (emit) pending_q.push_back(res);
    word_count++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Send a frame of random content, optionally skipping the frame start
  task automatic send_frame(int unsigned w, int unsigned h, bit mark);
    for (int unsigned i = 0; i < w * h; i++)
      send_pixel(24'($urandom()), mark && (i == 0));
  endtask

  // Receiver: random stalls and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk_i) begin
    filt_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.red   = m_axis_tdata[7:0];
      got.green = m_axis_tdata[15:8];
      got.blue  = m_axis_tdata[23:16];
      got.col   = m_axis_tdata[33:24];
      got.row   = m_axis_tdata[45:34];
      got.done  = m_axis_tlast;
      res_count++;
      if (pending_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("ERROR: unexpected word %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) $display("ERROR: expected %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  stim_row_t directed[$];

  initial begin
    stim_row_t sr;
    filt_word_t res;
    bit emit;
    bit wide_done, hold_done;
    int unsigned max_w;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_WIDTH;
    cfg_data_i    = '0;
    err_count = 0; word_count = 0; res_count = 0; idle_cycles = 0;
    tx_idle_en = 1'b0; rx_idle_en = 1'b0; long_hold = 1'b0;
    wide_done = 1'b0; hold_done = 1'b0; max_w = 3;
    for (int i = 0; i < 1024; i++) begin
      upper_mem[i] = '0;
      middle_mem[i] = '0;
    end
    for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) win[r][c] = '0;
    col_cnt = 0; row_cnt = 0;
    cfg_width = 11'd640; cfg_height = 13'd480;
    cfg_weights = 63'd268435456; cfg_div = 8'd1;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 3x3 frame, identity kernel, extremes of pixel values
    write_reg(REG_WIDTH, 63'd3);
    write_reg(REG_HEIGHT, 63'd3);
    for (int i = 0; i < 9; i++) begin
      sr.pix = (i == 4) ? 24'hff00ff : (i[0] ? 24'hffffff : 24'h000000);
      sr.sof = (i == 0);
      sr.check_fixed = (i == 8);
      sr.fixed = '{red: 8'hff, green: 8'h00, blue: 8'hff, col: 10'd1, row: 12'd1, done: 1'b1};
      directed.push_back(sr);
    end
    // Second frame without a frame start: counters wrap on their own
    for (int i = 0; i < 9; i++) begin
      sr.pix = 24'(24'h123456 * (i + 1));
      sr.sof = 1'b0;
      sr.check_fixed = 1'b0;
      directed.push_back(sr);
    end
    foreach (directed[k]) begin
      if (directed[k].check_fixed) begin
        predict_pixel(directed[k].pix, directed[k].sof, emit, res);
        if (res !== directed[k].fixed) begin
          err_count++;
          $display("ERROR: directed row %0d predicted %p", k, res);
        end
        pending_q.push_back(directed[k].fixed);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= directed[k].pix;
        s_axis_tuser  <= directed[k].sof;
        do @(posedge clk_i); while (!s_axis_tready);
        word_count++;
      end else begin
        send_pixel(directed[k].pix, directed[k].sof);
      end
    end
    wait_idle();

    // Negative kernel clamps to zero, then all-max kernel with divisor 255
    write_reg(REG_WEIGHTS, {9{7'h40}});
    write_reg(REG_DIVISOR, 63'd0);
    write_reg(REG_WIDTH, 63'd0);
    write_reg(REG_HEIGHT, 63'd0);
    send_frame(3, 3, 1'b1);
    wait_idle();
    write_reg(REG_WEIGHTS, {9{7'h3f}});
    write_reg(REG_DIVISOR, 63'd255);
    send_frame(3, 3, 1'b1);
    wait_idle();

    // Random part with idling on both sides
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (word_count < 1150) begin
      int unsigned w, h, n;
      bit mark, stress;
      stress = 1'b0;
      if (!wide_done && word_count > 200) begin
        w = $urandom_range(41, 120);
        wide_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(0, 2);
      end else begin
        w = $urandom_range(3, 12);
      end
      h = $urandom_range(0, 6);
      if (w > 40) h = 3;
      // Long receiver hold-off over a frame with many results
      if (!hold_done && word_count > 400) begin
        w = 8;
        h = 6;
        stress = 1'b1;
        hold_done = 1'b1;
        long_hold = 1'b1;
      end
      write_reg(REG_WIDTH, 63'(w));
      write_reg(REG_HEIGHT, 63'(h));
      write_reg(REG_WEIGHTS, ($urandom_range(0, 2) == 0) ? {9{7'h01}} :
                63'({$urandom(), $urandom()}));
      write_reg(REG_DIVISOR, ($urandom_range(0, 3) == 0) ? 63'd9 : 63'($urandom_range(0, 255)));
      if (word_count > 950) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      // Mostly whole frames, sometimes a truncated one
      if (w > 1024) w = 1024;
      if (w < 3) w = 3;
      if (h < 3) h = 3;
      // Skip the frame start only over columns the line stores already hold
      mark = ($urandom_range(0, 5) != 0) || (w > max_w);
      if (!stress && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, w * h);
        for (int unsigned i = 0; i < n; i++)
          send_pixel(24'($urandom()), i == 0);
      end else begin
        send_frame(w, h, mark);
      end
      wait_idle();
      // Restart the predictor position at a known frame start next time
      send_frame(w, 1, 1'b1);
      wait_idle();
      if (w > max_w) max_w = w;
    end
    wait_idle();

    $display("Run covered %0d pixels in and %0d filtered words out,", word_count, res_count);
    $display("over varied frame sizes, kernels, divisors and stall patterns.");
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
